/* hdl/scpu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package scpu_pkg;

  localparam int DATA_W    = 8;
  localparam int ADDR_W    = 8;
  localparam int MEM_DEPTH = 256;
  localparam int FLAG_W    = 4;

  // Bit positions inside the flag nibble.
  localparam int FLAG_ZERO  = 0;
  localparam int FLAG_EQUAL = 1;
  localparam int FLAG_LARGE = 2;
  localparam int FLAG_CARRY = 3;

  // Item kinds on the input channel.
  localparam logic ITEM_WRITE = 1'b0;
  localparam logic ITEM_EXEC  = 1'b1;

  // Top nibble of an opcode.
  typedef enum logic [3:0] {
    OP_LD    = 4'd0,
    OP_ST    = 4'd1,
    OP_DATA  = 4'd2,
    OP_JMPR  = 4'd3,
    OP_JMP   = 4'd4,
    OP_JCOND = 4'd5,
    OP_CLF   = 4'd6,
    OP_IO    = 4'd7,
    OP_ADD   = 4'd8,
    OP_SHR   = 4'd9,
    OP_SHL   = 4'd10,
    OP_NOT   = 4'd11,
    OP_AND   = 4'd12,
    OP_OR    = 4'd13,
    OP_XOR   = 4'd14,
    OP_CMP   = 4'd15
  } opcode_t;

  // ALU operation, the low three bits of an ALU opcode's top nibble.
  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_SHR = 3'd1,
    ALU_SHL = 3'd2,
    ALU_NOT = 3'd3,
    ALU_AND = 3'd4,
    ALU_OR  = 3'd5,
    ALU_XOR = 3'd6,
    ALU_CMP = 3'd7
  } alu_op_t;

  // I/O sub-operation, carried in the register A field.
  typedef enum logic [1:0] {
    IO_IN      = 2'd0,
    IO_GETADDR = 2'd1,
    IO_OUT     = 2'd2,
    IO_SETADDR = 2'd3
  } io_op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_FETCH,
    S_DECODE,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0] mem_data;
    logic [DATA_W-1:0] io_in_data;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] next_pc;
    logic [FLAG_W-1:0] flag_bits;
    logic              io_in_taken;
    logic              io_out_valid;
    logic [DATA_W-1:0] io_port;
    logic [DATA_W-1:0] io_out_data;
  } out_item_t;

  // What the ALU hands back to the core.
  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic [FLAG_W-1:0] flags;
    logic              wb;
  } alu_out_t;

endpackage

`default_nettype wire

/* hdl/scpu_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module scpu_ram import scpu_pkg::*; #(
  parameter int WIDTH = DATA_W,
  parameter int DEPTH = MEM_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

/* hdl/scpu_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

module scpu_alu import scpu_pkg::*; (
  input  wire logic [2:0]        op,
  input  wire logic [DATA_W-1:0] va,
  input  wire logic [DATA_W-1:0] vb,
  input  wire logic              cin,
  output alu_out_t               alu_out
);

  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] res;
  logic              carry;
  logic              wb;

  assign sum = {1'b0, va} + {1'b0, vb} + {{DATA_W{1'b0}}, cin};

  // Result and carry for each operation; CMP only compares.
  always_comb begin
    res   = '0;
    carry = 1'b0;
    wb    = 1'b1;
    unique case (alu_op_t'(op))
      ALU_ADD: begin
        res   = sum[DATA_W-1:0];
        carry = sum[DATA_W];
      end
      ALU_SHR: begin
        res   = {cin, va[DATA_W-1:1]};
        carry = va[0];
      end
      ALU_SHL: begin
        res   = {va[DATA_W-2:0], cin};
        carry = va[DATA_W-1];
      end
      ALU_NOT: res = ~va;
      ALU_AND: res = va & vb;
      ALU_OR:  res = va | vb;
      ALU_XOR: res = va ^ vb;
      ALU_CMP: wb = 1'b0;
      default: wb = 1'b0;
    endcase
  end

  // The compare flags always look at the operands before the operation.
  always_comb begin
    alu_out.res               = res;
    alu_out.wb                = wb;
    alu_out.flags             = '0;
    alu_out.flags[FLAG_CARRY] = carry;
    alu_out.flags[FLAG_LARGE] = (va > vb);
    alu_out.flags[FLAG_EQUAL] = (va == vb);
    alu_out.flags[FLAG_ZERO]  = wb && (res == '0);
  end

endmodule

`default_nettype wire

/* hdl/eight_bit_four_register_cpu_core.sv */
// Eight-bit CPU core with four general registers and a 256-byte memory.
// Input channel (in_valid/in_ready/in_data): each transfer is either a
// memory write item (operation 0: mem_addr, mem_data) or an execute item
// (operation 1) that runs the instruction at the program counter;
// io_in_data is the byte an input instruction would read.
// Result channel (out_valid/out_ready/out_data): one result per item with
// the next PC, the flags, the I/O address and any I/O activity.
// Write items complete in the fetch state, one write item per cycle while the
// result register is free. An instruction moves from fetch to decode, and
// LD also through a load state. The registered read of the program memory
// sets this: fetch reads the opcode and its following byte, and LD's load
// state waits for the operand read.
// A one-entry input register holds the current item until it completes and
// can take the next one as it does; the result register holds a finished result
// while the receiver stalls; the core waits with its reads held until it drains.
// Reset clears registers, PC, flags, I/O address and the memory valid
// bits, so unwritten memory reads as zero; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module eight_bit_four_register_cpu_core import scpu_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  state_t            state_r, state_nxt;
  in_item_t          ibuf_r;
  logic              ibuf_v_r;
  logic              out_v_r;
  out_item_t         out_r, out_nxt;
  logic [DATA_W-1:0] gpr_r [4];
  logic [ADDR_W-1:0] pc_r;
  logic [FLAG_W-1:0] flags_r;
  logic [DATA_W-1:0] ioaddr_r;
  logic [MEM_DEPTH-1:0] mvld_r;
  logic              vld_a_r, vld_b_r;

  logic [ADDR_W-1:0] addr_a, addr_b;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [DATA_W-1:0] mem_wd;
  logic [DATA_W-1:0] ram_a_q, ram_b_q;
  logic [DATA_W-1:0] opc, rd_b;

  opcode_t           top_op;
  logic [1:0]        ra, rb;
  logic [DATA_W-1:0] va, vb;
  alu_out_t          alu_res;

  logic [ADDR_W-1:0] ex_pc;
  logic [FLAG_W-1:0] ex_flags;
  logic [DATA_W-1:0] ex_ioaddr;
  logic              ex_reg_we;
  logic [DATA_W-1:0] ex_reg_wd;
  logic              ex_taken;
  logic              ex_ovalid;
  logic [DATA_W-1:0] ex_odata;

  logic out_free;
  logic wr_done;
  logic ex_done;
  logic consume;

  // Unwritten memory bytes read as zero.
  assign opc  = vld_a_r ? ram_a_q : '0;
  assign rd_b = vld_b_r ? ram_b_q : '0;

  assign top_op = opcode_t'(opc[7:4]);
  assign ra     = opc[3:2];
  assign rb     = opc[1:0];
  assign va     = gpr_r[ra];
  assign vb     = gpr_r[rb];

  assign out_free = !out_v_r || out_ready;
  assign wr_done  = (state_r == S_FETCH) && ibuf_v_r
                    && (ibuf_r.operation == ITEM_WRITE) && out_free;
  assign ex_done  = out_free && ((state_r == S_LOAD)
                    || ((state_r == S_DECODE) && (top_op != OP_LD)));
  assign consume  = wr_done || ex_done;
  assign in_ready = !ibuf_v_r || consume;

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Port A always reads the opcode; port B reads the following byte or,
  // for LD, the operand byte.
  always_comb begin
    addr_a = pc_r;
    addr_b = pc_r + 8'd1;
    if ((state_r == S_LOAD) || ((state_r == S_DECODE) && (top_op == OP_LD))) begin
      addr_b = va;
    end
  end

  // Memory write: a write item in fetch, or ST when it completes.
  always_comb begin
    mem_we = wr_done || (ex_done && (state_r == S_DECODE) && (top_op == OP_ST));
    mem_wa = (state_r == S_FETCH) ? ibuf_r.mem_addr : va;
    mem_wd = (state_r == S_FETCH) ? ibuf_r.mem_data : vb;
  end

  scpu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram_a (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (mem_wa),
    .wr_data   (mem_wd),
    .rd_addr   (addr_a),
    .rd_data_r (ram_a_q)
  );

  scpu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram_b (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (mem_wa),
    .wr_data   (mem_wd),
    .rd_addr   (addr_b),
    .rd_data_r (ram_b_q)
  );

  scpu_alu u_alu (
    .op      (opc[6:4]),
    .va      (va),
    .vb      (vb),
    .cin     (flags_r[FLAG_CARRY]),
    .alu_out (alu_res)
  );

  // Instruction execute: next architectural values for one instruction.
  always_comb begin
    ex_pc     = pc_r + 8'd1;
    ex_flags  = flags_r;
    ex_ioaddr = ioaddr_r;
    ex_reg_we = 1'b0;
    ex_reg_wd = '0;
    ex_taken  = 1'b0;
    ex_ovalid = 1'b0;
    ex_odata  = '0;
    unique case (top_op) inside
      OP_LD: begin
        ex_reg_we = 1'b1;
        ex_reg_wd = rd_b;
      end
      OP_ST: begin
        ex_reg_we = 1'b0;
      end
      OP_DATA: begin
        ex_reg_we = 1'b1;
        ex_reg_wd = rd_b;
        ex_pc     = pc_r + 8'd2;
      end
      OP_JMPR: ex_pc = vb;
      OP_JMP:  ex_pc = rd_b;
      OP_JCOND: begin
        ex_pc = ((flags_r & opc[3:0]) != '0) ? rd_b : pc_r + 8'd2;
      end
      OP_CLF: ex_flags = '0;
      OP_IO: begin
        unique case (io_op_t'(ra))
          IO_IN: begin
            ex_reg_we = 1'b1;
            ex_reg_wd = ibuf_r.io_in_data;
            ex_taken  = 1'b1;
          end
          IO_GETADDR: begin
            ex_reg_we = 1'b1;
            ex_reg_wd = ioaddr_r;
          end
          IO_OUT: begin
            ex_ovalid = 1'b1;
            ex_odata  = vb;
          end
          IO_SETADDR: ex_ioaddr = vb;
          default: ex_ioaddr = ioaddr_r;
        endcase
      end
      OP_ADD, OP_SHR, OP_SHL, OP_NOT, OP_AND, OP_OR, OP_XOR, OP_CMP: begin
        ex_flags  = alu_res.flags;
        ex_reg_we = alu_res.wb;
        ex_reg_wd = alu_res.res;
      end
      default: ex_pc = pc_r + 8'd1;
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_FETCH: begin
        if (ibuf_v_r && (ibuf_r.operation == ITEM_EXEC)) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (top_op == OP_LD) begin
          state_nxt = S_LOAD;
        end else if (out_free) begin
          state_nxt = S_FETCH;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          state_nxt = S_FETCH;
        end
      end
      default: state_nxt = S_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FETCH;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Result contents for the item that completes this cycle.
  always_comb begin
    if (state_r == S_FETCH) begin
      out_nxt.next_pc      = pc_r;
      out_nxt.flag_bits    = flags_r;
      out_nxt.io_in_taken  = 1'b0;
      out_nxt.io_out_valid = 1'b0;
      out_nxt.io_port      = ioaddr_r;
      out_nxt.io_out_data  = '0;
    end else begin
      out_nxt.next_pc      = ex_pc;
      out_nxt.flag_bits    = ex_flags;
      out_nxt.io_in_taken  = ex_taken;
      out_nxt.io_out_valid = ex_ovalid;
      out_nxt.io_port      = ex_ioaddr;
      out_nxt.io_out_data  = ex_odata;
    end
  end

  // Input register, result register and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ibuf_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      pc_r     <= '0;
      flags_r  <= '0;
      ioaddr_r <= '0;
      mvld_r   <= '0;
      for (int i = 0; i < 4; i++) begin
        gpr_r[i] <= '0;
      end
    end else begin
      if (in_valid && in_ready) begin
        ibuf_v_r <= 1'b1;
      end else if (consume) begin
        ibuf_v_r <= 1'b0;
      end
      if (consume) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (mem_we) begin
        mvld_r[mem_wa] <= 1'b1;
      end
      if (ex_done) begin
        pc_r     <= ex_pc;
        flags_r  <= ex_flags;
        ioaddr_r <= ex_ioaddr;
        if (ex_reg_we) begin
          gpr_r[rb] <= ex_reg_wd;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ibuf_r <= in_data;
    end
    if (consume) begin
      out_r <= out_nxt;
    end
    vld_a_r <= mvld_r[addr_a];
    vld_b_r <= mvld_r[addr_b];
  end

endmodule

`default_nettype wire

/* hdl/scpu_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module scpu_checker import scpu_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An offered input item holds until its transfer.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input item changed while stalled");

  // Nothing is shown right after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // An instruction either reads input or emits output, never both.
  a_io_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.io_in_taken && out_data.io_out_valid))
    else $error("input and output in one result");

  // Output data is zero unless an output byte is emitted.
  a_odata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.io_out_valid |-> out_data.io_out_data == '0)
    else $error("output data without output valid");

endmodule

bind eight_bit_four_register_cpu_core scpu_checker u_scpu_checker (.*);

`default_nettype wire

/* sim/tb_eight_bit_four_register_cpu_core.sv */
`timescale 1ns / 1ps

module tb_eight_bit_four_register_cpu_core;
  import scpu_pkg::*;

  localparam int ITEM_TARGET  = 1600;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 100;

  // General register indexes as they appear in the opcode fields.
  localparam logic [1:0] R0 = 2'd0;
  localparam logic [1:0] R1 = 2'd1;
  localparam logic [1:0] R2 = 2'd2;
  localparam logic [1:0] R3 = 2'd3;

  // Flag mask for a conditional jump on carry alone.
  localparam logic [FLAG_W-1:0] CARRY_MASK = FLAG_W'(1 << FLAG_CARRY);

  // Shadow copy of the CPU state plus the results it still owes.
  class cpu_shadow;
    logic [DATA_W-1:0] mem [MEM_DEPTH];
    logic [DATA_W-1:0] regs [4];
    logic [ADDR_W-1:0] pc;
    logic [FLAG_W-1:0] flags;
    logic [DATA_W-1:0] io_addr;
    out_item_t         results_due [$];
    int                mismatches;

    function new();
      foreach (mem[i]) mem[i] = '0;
      foreach (regs[i]) regs[i] = '0;
      pc         = '0;
      flags      = '0;
      io_addr    = '0;
      mismatches = 0;
    endfunction

    // Apply one accepted input transfer and queue the result it causes.
    function void note_item(in_item_t it);
      out_item_t         r;
      logic [DATA_W-1:0] opc;
      logic [DATA_W-1:0] follow;
      logic [DATA_W-1:0] va;
      logic [DATA_W-1:0] vb;
      logic [DATA_W-1:0] res;
      logic [ADDR_W-1:0] npc;
      logic [1:0]        ra;
      logic [1:0]        rb;
      logic [DATA_W:0]   sum;
      logic [FLAG_W-1:0] f;
      logic              cin;
      r = '0;
      if (it.operation == ITEM_WRITE) begin
        mem[it.mem_addr] = it.mem_data;
      end else begin
        opc    = mem[pc];
        ra     = opc[3:2];
        rb     = opc[1:0];
        npc    = pc + 8'd1;
        follow = mem[npc];
        if (opc[7]) begin
          // ALU: compare flags use the operands before the write back.
          va  = regs[ra];
          vb  = regs[rb];
          cin = flags[FLAG_CARRY];
          f   = '0;
          f[FLAG_LARGE] = (va > vb);
          f[FLAG_EQUAL] = (va == vb);
          res = '0;
          case (alu_op_t'(opc[6:4]))
            ALU_ADD: begin
              sum = {1'b0, va} + {1'b0, vb} + {8'd0, cin};
              res = sum[DATA_W-1:0];
              f[FLAG_CARRY] = sum[DATA_W];
            end
            ALU_SHR: begin
              res = {cin, va[7:1]};
              f[FLAG_CARRY] = va[0];
            end
            ALU_SHL: begin
              res = {va[6:0], cin};
              f[FLAG_CARRY] = va[7];
            end
            ALU_NOT: res = ~va;
            ALU_AND: res = va & vb;
            ALU_OR:  res = va | vb;
            ALU_XOR: res = va ^ vb;
            default: ;
          endcase
          // CMP only updates the flags.
          if (alu_op_t'(opc[6:4]) != ALU_CMP) begin
            f[FLAG_ZERO] = (res == '0);
            regs[rb] = res;
          end
          flags = f;
        end else begin
          case (opcode_t'(opc[7:4]))
            OP_LD:   regs[rb] = mem[regs[ra]];
            OP_ST:   mem[regs[ra]] = regs[rb];
            OP_DATA: begin
              regs[rb] = follow;
              npc = pc + 8'd2;
            end
            OP_JMPR: npc = regs[rb];
            OP_JMP:  npc = follow;
            OP_JCOND: begin
              if ((flags & opc[3:0]) != '0) npc = follow;
              else npc = pc + 8'd2;
            end
            OP_CLF:  flags = '0;
            OP_IO: begin
              case (io_op_t'(ra))
                IO_IN: begin
                  regs[rb] = it.io_in_data;
                  r.io_in_taken = 1'b1;
                end
                IO_GETADDR: regs[rb] = io_addr;
                IO_OUT: begin
                  r.io_out_valid = 1'b1;
                  r.io_out_data  = regs[rb];
                end
                default: io_addr = regs[rb];
              endcase
            end
            default: ;
          endcase
        end
        pc = npc;
      end
      r.next_pc   = pc;
      r.flag_bits = flags;
      r.io_port   = io_addr;
      results_due.push_back(r);
    endfunction

    // Compare one result transfer with the oldest pending result.
    function void check_result(out_item_t got);
      out_item_t want;
      if (results_due.size() == 0) begin
        $error("result transfer with no result pending: %h", got);
        mismatches++;
        return;
      end
      want = results_due.pop_front();
      if (got.next_pc !== want.next_pc) begin
        $error("next_pc: expected %0d, actual %0d", want.next_pc, got.next_pc);
        mismatches++;
      end
      if (got.flag_bits !== want.flag_bits) begin
        $error("flag_bits: expected %b, actual %b", want.flag_bits, got.flag_bits);
        mismatches++;
      end
      if (got.io_in_taken !== want.io_in_taken) begin
        $error("io_in_taken: expected %b, actual %b", want.io_in_taken,
               got.io_in_taken);
        mismatches++;
      end
      if (got.io_out_valid !== want.io_out_valid) begin
        $error("io_out_valid: expected %b, actual %b", want.io_out_valid,
               got.io_out_valid);
        mismatches++;
      end
      if (got.io_port !== want.io_port) begin
        $error("io_port: expected %0d, actual %0d", want.io_port, got.io_port);
        mismatches++;
      end
      if (got.io_out_data !== want.io_out_data) begin
        $error("io_out_data: expected %0d, actual %0d", want.io_out_data,
               got.io_out_data);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_data = '0;
  logic      in_ready;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  cpu_shadow shadow = new();

  int send_idle_pct = 6;
  int recv_idle_pct = 88;
  int rx_hold_left  = 0;
  int items_sent    = 0;
  int stall_count   = 0;

  eight_bit_four_register_cpu_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Check every result transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      shadow.check_result(out_data);
    end
  end

  // Give up when nothing has moved on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
    end
    if (stall_count >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Bytes that favor the extremes.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Present one item after a random gap and hold it until the transfer.
  // Called and returns at a falling edge.
  task automatic offer_item(in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shadow.note_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_write(logic [7:0] addr, logic [7:0] data);
    offer_item(in_item_t'({ITEM_WRITE, addr, data, rand_byte()}));
  endtask

  task automatic send_exec(logic [7:0] io_byte);
    offer_item(in_item_t'({ITEM_EXEC, rand_byte(), rand_byte(), io_byte}));
  endtask

  // Place an instruction at the current PC, its operand byte if it has one,
  // and then execute it.
  task automatic run_instr(logic [7:0] opc, logic [7:0] operand,
                           logic [7:0] io_byte);
    send_write(shadow.pc, opc);
    if (opc[7:4] == OP_DATA || opc[7:4] == OP_JMP || opc[7:4] == OP_JCOND) begin
      send_write(shadow.pc + 8'd1, operand);
    end
    send_exec(io_byte);
  endtask

  // Mostly well-formed instructions with random content; the rest runs
  // whatever memory holds or scribbles over random addresses.
  task automatic random_step();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      run_instr(8'($urandom_range(0, 255)), rand_byte(), rand_byte());
    end else if (pick < 85) begin
      send_exec(rand_byte());
    end else begin
      send_write(8'($urandom_range(0, 255)), rand_byte());
    end
  endtask

  // Stop offering and wait until every pending result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (shadow.results_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed program: every opcode and I/O sub-operation, carry in and
    // out, a taken and a skipped conditional jump, and PC wrap at 255.
    run_instr({OP_DATA, R0, R1}, 8'hFF, 8'h00);
    run_instr({OP_IO, IO_IN, R2}, 8'h00, 8'h01);
    run_instr({OP_ADD, R1, R2}, 8'h00, 8'h00);
    run_instr({OP_SHL, R1, R3}, 8'h00, 8'h00);
    run_instr({OP_SHR, R3, R0}, 8'h00, 8'h00);
    run_instr({OP_JCOND, CARRY_MASK}, 8'hFE, 8'h00);
    run_instr({OP_DATA, R0, R0}, 8'h80, 8'h00);
    run_instr({OP_NOT, R0, R2}, 8'h00, 8'h00);
    run_instr({OP_AND, R1, R2}, 8'h00, 8'h00);
    run_instr({OP_OR, R2, R3}, 8'h00, 8'h00);
    run_instr({OP_XOR, R3, R3}, 8'h00, 8'h00);
    run_instr({OP_CMP, R1, R1}, 8'h00, 8'h00);
    run_instr({OP_JCOND, CARRY_MASK}, 8'h10, 8'h00);
    run_instr({OP_CLF, R0, R0}, 8'h00, 8'h00);
    run_instr({OP_ST, R2, R0}, 8'h00, 8'h00);
    run_instr({OP_LD, R2, R1}, 8'h00, 8'h00);
    run_instr({OP_IO, IO_SETADDR, R2}, 8'h00, 8'h00);
    run_instr({OP_IO, IO_GETADDR, R3}, 8'h00, 8'h00);
    run_instr({OP_IO, IO_OUT, R0}, 8'h00, 8'h00);
    run_instr({OP_IO, IO_IN, R1}, 8'h00, 8'hFF);
    run_instr({OP_JMP, R0, R0}, 8'hFF, 8'h00);
    run_instr({OP_JMPR, R0, R3}, 8'h00, 8'h00);

    // Random items, first with a slow receiver.
    while (items_sent < ITEM_TARGET / 3) random_step();
    drain();

    // Then with a slow sender.
    send_idle_pct = 88;
    recv_idle_pct = 6;
    while (items_sent < 2 * ITEM_TARGET / 3) random_step();
    drain();

    // Full rate, opening with a long receiver hold-off so the core backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rx_hold_left  = HOLD_CYCLES;
    while (items_sent < ITEM_TARGET) random_step();
    drain();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (shadow.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
